// ===== design/tpcd_pkg.sv =====
// Shared types and constants for the prefix-code decoder.
`timescale 1ns / 1ps
package tpcd_pkg;
    localparam int LEN_W  = 5;
    localparam int CODE_W = 16;
    localparam int BYTE_W = 8;
    localparam int NV_W   = 4;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ENTRY = 2'd1,
        REQ_DATA  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef struct packed {
        logic clr;
        logic wr;
        logic rd;
    } tbl_cmd_t;
endpackage

// ===== design/tpcd_table.sv =====
// Code table: one synchronous memory of length and code per symbol, valid flags.
`timescale 1ns / 1ps
module tpcd_table
    import tpcd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tbl_cmd_t                        cmd,
    input  logic [BYTE_W-1:0]               wr_sym,
    input  logic [CODE_W-1:0]               wr_code,
    input  logic [LEN_W-1:0]                wr_len,
    input  logic [$clog2(SYMBOL_COUNT)-1:0] rd_addr,
    output logic                            rd_vld,
    output logic [LEN_W-1:0]                rd_len,
    output logic [CODE_W-1:0]               rd_code,
    output logic [LEN_W-1:0]                longest
);
    localparam int SYM_W = $clog2(SYMBOL_COUNT);

    logic [LEN_W+CODE_W-1:0] mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] vld_reg;
    logic [LEN_W-1:0]        longest_reg;
    logic                    rd_vld_reg;
    logic [LEN_W+CODE_W-1:0] rd_reg;
    logic                    wr_ok;
    logic [CODE_W-1:0]       code_masked;

    assign wr_ok = cmd.wr && ({1'b0, wr_sym} < (BYTE_W+1)'(SYMBOL_COUNT))
                   && ({1'b0, wr_len} <= (LEN_W+1)'(MAX_CODE_LEN));
    assign code_masked = wr_code & ~({CODE_W{1'b1}} << wr_len);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr_sym[SYM_W-1:0]] <= {wr_len, code_masked};
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            longest_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
            begin
                vld_reg     <= '0;
                longest_reg <= '0;
            end
            else if (wr_ok)
            begin
                vld_reg[wr_sym[SYM_W-1:0]] <= 1'b1;
                if (wr_len > longest_reg)
                begin
                    longest_reg <= wr_len;
                end
            end
            if (cmd.rd)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_vld  = rd_vld_reg;
    assign rd_len  = rd_reg[LEN_W+CODE_W-1:CODE_W];
    assign rd_code = rd_reg[CODE_W-1:0];
    assign longest = longest_reg;
endmodule

// ===== design/table_prefix_code_decoder.sv =====
// Top level: bit buffer, table search sequencer and output word register.
// Usage: input words carry a request in req_type: clear table, write one
// table entry, or deliver a stream byte (valid_bits leading bits, MSB first,
// last_byte marks the end of a stream). Table requests complete in the idle
// state. A data word is decoded while enough bits are pending (or until empty
// on the final byte). Each decoded position sweeps the whole table through
// its single memory read port: a check state, a scan state that reads every
// entry, then tail and resolve states; at most MAX_CODE_LEN + 7 symbols are
// resolved per data word. With an empty table each pending bit is dropped in
// the check state without a scan. Output words carry symbol and last_in_run,
// which marks the final symbol of an input word. in_ready is high only
// between data words.
// The result sits in an output register; while it is full and out_ready is
// low the sequencer holds its next symbol and waits. Reset clears table valid
// flags, longest length, pending bits and out_valid; the state goes to idle.
`timescale 1ns / 1ps
module table_prefix_code_decoder
    import tpcd_pkg::*;
#(
    parameter int MAX_CODE_LEN = 16,
    parameter int SYMBOL_COUNT = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  logic [7:0]        entry_symbol,
    input  logic [15:0]       entry_code,
    input  logic [4:0]        entry_length,
    input  logic [7:0]        data_byte,
    input  logic [3:0]        valid_bits,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        symbol,
    output logic              last_in_run
);
    localparam int SYM_W   = $clog2(SYMBOL_COUNT);
    localparam int PEND_W  = MAX_CODE_LEN + 7;
    localparam int CNT_W   = $clog2(PEND_W + 1);
    localparam int MAX_RES = MAX_CODE_LEN + 7;
    localparam int RES_W   = $clog2(MAX_RES + 1);
    localparam int CMP_W   = (PEND_W > CODE_W) ? PEND_W : CODE_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHECK, ST_SCAN, ST_TAIL, ST_RESOLVE, ST_FLUSH
    } state_t;

    state_t              state_reg, state_next;
    logic [PEND_W-1:0]   pend_reg, pend_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                last_reg, last_next;
    logic [RES_W-1:0]    nres_reg, nres_next;
    logic [LEN_W-1:0]    top_reg, top_next;
    logic [SYM_W-1:0]    addr_reg, addr_next;
    logic                cmp_en_reg, cmp_en_next;
    logic [SYM_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic [LEN_W-1:0]    best_len_reg, best_len_next;
    logic [SYM_W-1:0]    best_sym_reg, best_sym_next;
    logic                hold_v_reg, hold_v_next;
    logic [SYM_W-1:0]    hold_sym_reg, hold_sym_next;
    logic                out_v_reg, out_v_next;
    logic [7:0]          out_sym_reg, out_sym_next;
    logic                out_last_reg, out_last_next;

    tbl_cmd_t            cmd;
    logic                rd_vld;
    logic [LEN_W-1:0]    rd_len;
    logic [CODE_W-1:0]   rd_code;
    logic [LEN_W-1:0]    longest;
    logic                accept;
    logic                out_free;
    logic [NV_W-1:0]     nv;
    logic [CNT_W-1:0]    shamt;
    logic [PEND_W-1:0]   field;
    logic                hit;

    tpcd_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wr_sym  (entry_symbol),
        .wr_code (entry_code),
        .wr_len  (entry_length),
        .rd_addr (addr_reg),
        .rd_vld  (rd_vld),
        .rd_len  (rd_len),
        .rd_code (rd_code),
        .longest (longest)
    );

    assign in_ready    = (state_reg == ST_IDLE);
    assign accept      = in_valid && in_ready;
    assign out_free    = !out_v_reg || out_ready;
    assign out_valid   = out_v_reg;
    assign symbol      = out_sym_reg;
    assign last_in_run = out_last_reg;

    assign nv    = (valid_bits > NV_W'(8)) ? NV_W'(8) : valid_bits;
    assign shamt = cnt_reg - CNT_W'(rd_len);
    assign field = (pend_reg >> shamt) & ~({PEND_W{1'b1}} << rd_len);
    assign hit   = cmp_en_reg && rd_vld && (rd_len != '0) && (rd_len <= top_reg)
                   && (rd_len > best_len_reg) && (CMP_W'(field) == CMP_W'(rd_code));

    always_comb
    begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        cnt_next      = cnt_reg;
        last_next     = last_reg;
        nres_next     = nres_reg;
        top_next      = top_reg;
        addr_next     = addr_reg;
        cmp_en_next   = 1'b0;
        cmp_idx_next  = addr_reg;
        best_len_next = best_len_reg;
        best_sym_next = best_sym_reg;
        hold_v_next   = hold_v_reg;
        hold_sym_next = hold_sym_reg;
        out_v_next    = out_v_reg && !out_ready;
        out_sym_next  = out_sym_reg;
        out_last_next = out_last_reg;
        cmd           = '0;

        if (hit)
        begin
            best_len_next = rd_len;
            best_sym_next = cmp_idx_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_t'(req_type))
                        REQ_CLEAR: cmd.clr = 1'b1;
                        REQ_ENTRY: cmd.wr  = 1'b1;
                        REQ_DATA:
                        begin
                            if (nv != '0)
                            begin
                                pend_next = (pend_reg << nv)
                                          | PEND_W'(data_byte >> (NV_W'(8) - nv));
                                cnt_next  = cnt_reg + CNT_W'(nv);
                            end
                            last_next  = last_byte;
                            nres_next  = '0;
                            state_next = ST_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CHECK:
            begin
                if ((cnt_reg != '0) && (nres_reg < RES_W'(MAX_RES))
                    && (last_reg || (32'(cnt_reg) >= 32'(longest))))
                begin
                    if (32'(longest) > 32'(cnt_reg))
                    begin
                        top_next = LEN_W'(cnt_reg);
                    end
                    else
                    begin
                        top_next = longest;
                    end
                    if ((longest == '0))
                    begin
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                    else
                    begin
                        best_len_next = '0;
                        addr_next     = '0;
                        state_next    = ST_SCAN;
                    end
                end
                else
                begin
                    if (last_reg)
                    begin
                        cnt_next  = '0;
                        pend_next = '0;
                    end
                    state_next = hold_v_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.rd      = 1'b1;
                cmp_en_next = 1'b1;
                if (32'(addr_reg) == SYMBOL_COUNT - 1)
                begin
                    state_next = ST_TAIL;
                end
                else
                begin
                    addr_next = addr_reg + SYM_W'(1);
                end
            end
            ST_TAIL:
            begin
                state_next = ST_RESOLVE;
            end
            ST_RESOLVE:
            begin
                if (best_len_reg == '0)
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    state_next = ST_CHECK;
                end
                else if (!hold_v_reg || out_free)
                begin
                    if (hold_v_reg)
                    begin
                        out_v_next    = 1'b1;
                        out_sym_next  = 8'(hold_sym_reg);
                        out_last_next = 1'b0;
                    end
                    hold_v_next   = 1'b1;
                    hold_sym_next = best_sym_reg;
                    nres_next     = nres_reg + RES_W'(1);
                    cnt_next      = cnt_reg - CNT_W'(best_len_reg);
                    state_next    = ST_CHECK;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_v_next    = 1'b1;
                    out_sym_next  = 8'(hold_sym_reg);
                    out_last_next = 1'b1;
                    hold_v_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            cnt_reg      <= '0;
            last_reg     <= 1'b0;
            nres_reg     <= '0;
            top_reg      <= '0;
            addr_reg     <= '0;
            cmp_en_reg   <= 1'b0;
            cmp_idx_reg  <= '0;
            best_len_reg <= '0;
            best_sym_reg <= '0;
            hold_v_reg   <= 1'b0;
            hold_sym_reg <= '0;
            out_v_reg    <= 1'b0;
            out_sym_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            cnt_reg      <= cnt_next;
            last_reg     <= last_next;
            nres_reg     <= nres_next;
            top_reg      <= top_next;
            addr_reg     <= addr_next;
            cmp_en_reg   <= cmp_en_next;
            cmp_idx_reg  <= cmp_idx_next;
            best_len_reg <= best_len_next;
            best_sym_reg <= best_sym_next;
            hold_v_reg   <= hold_v_next;
            hold_sym_reg <= hold_sym_next;
            out_v_reg    <= out_v_next;
            out_sym_reg  <= out_sym_next;
            out_last_reg <= out_last_next;
        end
    end
endmodule
